>>> rtl/tssm_pkg.sv
// shared types and codes for the two-stack shared memory block
`default_nettype none
package tssm_pkg;

    // fixed field widths
    localparam int DATA_W = 32;
    localparam int CNT_W  = 7;

    // command codes
    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_POP     = 2'd1;
    localparam logic [1:0] CMD_DISPLAY = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    // configuration register index
    localparam logic REG_TOTAL_SIZE = 1'b0;

    // input beat
    typedef struct packed {
        logic [1:0]               command;
        logic                     stack_select;
        logic signed [DATA_W-1:0] push_value;
    } t_in;

    // output beat
    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } t_out;

endpackage
`default_nettype wire

>>> rtl/two_stack_shared_memory.sv
// Two stacks in one memory: stack one grows up from entry 0, stack two grows down from
// entry total_size-1. One item is handled at a time through a single-port ram with a
// registered read and one shared slot address unit. A push or a pop goes through the
// calc step (address and ram access), then the result beat, and so do a full push, an
// empty pop or display; a display reads its stack one entry at a time through calc and
// wait, paced by the registered ram read, and holds while the output side stalls. Command
// 3 is dropped with no result. Writing total_size (clamped to 1..MEMORY_DEPTH) empties
// both stacks; memory contents are not cleared and need no clearing pass.
`default_nettype none
module two_stack_shared_memory #(
    parameter int MEMORY_DEPTH = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input channel
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire tssm_pkg::t_in          i_data,
    // output channel
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output tssm_pkg::t_out              o_data,
    // configuration port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready
);

    localparam int AW = $clog2(MEMORY_DEPTH);
    localparam int CW = tssm_pkg::CNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(MEMORY_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_WAIT,
        S_EMIT
    } t_state;

    t_state                       r_state;
    logic [1:0]                   r_cmd;
    logic                         r_sel;
    logic [tssm_pkg::DATA_W-1:0]  r_value;
    logic [CW-1:0]                r_k;
    logic [CW-1:0]                r_size;
    logic [CW-1:0]                r_lower;
    logic [CW-1:0]                r_upper;
    tssm_pkg::t_out               r_pend;
    tssm_pkg::t_out               r_out;
    logic                         r_out_valid;

    logic [CW-1:0]                w_cnt;
    logic [CW:0]                  w_used;
    logic                         w_full;
    logic                         w_empty;
    logic                         w_out_free;
    logic                         w_beat_load;
    logic [CW-1:0]                w_entry;
    logic [AW-1:0]                w_index;
    logic                         w_we;
    logic                         w_re;
    logic [tssm_pkg::DATA_W-1:0]  w_rdata;
    logic                         w_rd_last;
    logic                         w_cfg_wr;
    logic [CW-1:0]                w_size_in;
    logic [CW-1:0]                w_size_clamped;

    // stack bookkeeping
    assign w_cnt      = r_sel ? r_upper : r_lower;
    assign w_used     = {1'b0, r_lower} + {1'b0, r_upper};
    assign w_full     = w_used >= {1'b0, r_size};
    assign w_empty    = (w_cnt == '0);
    assign w_out_free = !r_out_valid || !i_stall;

    // a new result beat enters the output register
    assign w_beat_load = w_out_free && ((r_state == S_WAIT) || (r_state == S_EMIT));

    // entry number fed to the address unit
    always_comb begin
        case (r_cmd)
            tssm_pkg::CMD_PUSH: w_entry = w_cnt;
            tssm_pkg::CMD_POP:  w_entry = w_cnt - CW'(1);
            default:            w_entry = r_k;
        endcase
    end

    tssm_addr #(
        .MEMORY_DEPTH(MEMORY_DEPTH)
    ) u_addr (
        .i_upper (r_sel),
        .i_size  (r_size),
        .i_entry (w_entry),
        .o_index (w_index)
    );

    // ram access happens in the calc step only
    assign w_we = (r_state == S_CALC) && (r_cmd == tssm_pkg::CMD_PUSH) && !w_full;
    assign w_re = (r_state == S_CALC) && !w_empty &&
                  ((r_cmd == tssm_pkg::CMD_POP) || (r_cmd == tssm_pkg::CMD_DISPLAY));

    tssm_ram #(
        .WIDTH(tssm_pkg::DATA_W),
        .DEPTH(MEMORY_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_index),
        .i_wdata (r_value),
        .o_rdata (w_rdata)
    );

    assign w_rd_last = (r_cmd == tssm_pkg::CMD_POP) || ((r_k + CW'(1)) == w_cnt);

    // configuration decode and size clamp
    assign w_cfg_wr  = psel && penable && pwrite && (paddr[2] == tssm_pkg::REG_TOTAL_SIZE);
    assign w_size_in = pwdata[CW-1:0];
    always_comb begin
        if (w_size_in == '0) begin
            w_size_clamped = CW'(1);
        end else if (w_size_in > DEPTH_C) begin
            w_size_clamped = DEPTH_C;
        end else begin
            w_size_clamped = w_size_in;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == tssm_pkg::REG_TOTAL_SIZE) ? {{(32-CW){1'b0}}, r_size} : '0;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // sequencer, counts and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= DEPTH_C;
            r_lower     <= '0;
            r_upper     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_beat_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                r_size  <= w_size_clamped;
                r_lower <= '0;
                r_upper <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= i_data.command;
                        r_sel   <= i_data.stack_select;
                        r_value <= i_data.push_value;
                        r_k     <= '0;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    case (r_cmd)
                        tssm_pkg::CMD_PUSH: begin
                            if (w_full) begin
                                r_pend <= '{status: tssm_pkg::ST_OVERFLOW, value: '0, last: 1'b1};
                            end else begin
                                r_pend <= '{status: tssm_pkg::ST_OK,
                                            value: signed'(r_value), last: 1'b1};
                                if (r_sel) begin
                                    r_upper <= r_upper + CW'(1);
                                end else begin
                                    r_lower <= r_lower + CW'(1);
                                end
                            end
                            r_state <= S_EMIT;
                        end
                        tssm_pkg::CMD_POP, tssm_pkg::CMD_DISPLAY: begin
                            if (w_empty) begin
                                r_pend  <= '{status: tssm_pkg::ST_EMPTY, value: '0, last: 1'b1};
                                r_state <= S_EMIT;
                            end else begin
                                if (r_cmd == tssm_pkg::CMD_POP) begin
                                    if (r_sel) begin
                                        r_upper <= r_upper - CW'(1);
                                    end else begin
                                        r_lower <= r_lower - CW'(1);
                                    end
                                end
                                r_state <= S_WAIT;
                            end
                        end
                        default: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_WAIT: begin
                    // read data holds until the next read, so wait here on a stall
                    if (w_out_free) begin
                        r_out <= '{status: tssm_pkg::ST_OK,
                                   value: signed'(w_rdata), last: w_rd_last};
                        if (w_rd_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + CW'(1);
                            r_state <= S_CALC;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out   <= r_pend;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // the two stacks never hold more than the active region
    a_used_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= {1'b0, r_size})
        else $error("stacks exceed total size");

    // a successful push grows the total by exactly one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && !w_cfg_wr) |=> (w_used == $past(w_used) + (CW+1)'(1)))
        else $error("push did not grow stack");

    // a display read never walks past the stack top
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && r_cmd == tssm_pkg::CMD_DISPLAY) |-> (r_k < w_cnt))
        else $error("display walked past stack top");

    // non-ok results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != tssm_pkg::ST_OK) |-> (r_out.value == '0 && r_out.last))
        else $error("error beat malformed");

endmodule
`default_nettype wire

>>> rtl/tssm_ram.sv
// generic single-port ram with registered read
`default_nettype none
module tssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read share one address
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> rtl/tssm_addr.sv
// slot address unit: maps an entry number of either stack to a memory index
`default_nettype none
module tssm_addr #(
    parameter int MEMORY_DEPTH = 64
) (
    input  wire logic                            i_upper,
    input  wire logic [tssm_pkg::CNT_W-1:0]      i_size,
    input  wire logic [tssm_pkg::CNT_W-1:0]      i_entry,
    output logic      [$clog2(MEMORY_DEPTH)-1:0] o_index
);

    localparam int AW = $clog2(MEMORY_DEPTH);

    logic [tssm_pkg::CNT_W-1:0] w_down;
    logic [tssm_pkg::CNT_W-1:0] w_index;

    // upper stack counts down from the top of the active region
    assign w_down  = i_size - i_entry - tssm_pkg::CNT_W'(1);
    assign w_index = i_upper ? w_down : i_entry;
    assign o_index = w_index[AW-1:0];

endmodule
`default_nettype wire
